>>> design/pso_pkg.sv
// shared types, constants and helper functions for the particle swarm step
`timescale 1ns / 1ps
`default_nettype none

package pso_pkg;

  localparam int POS_W = 24;
  localparam int FIT_W = 18;
  localparam int GAIN_W = 16;
  localparam int RAND_W = 16;
  localparam int IDX_W = 5;
  localparam int CFG_IDX_W = 2;
  localparam int IN_DATA_W = 168;
  localparam int OUT_DATA_W = 144;

  // register indexes of the configuration port
  localparam logic [CFG_IDX_W-1:0] CFG_GLOBAL_GAIN = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PERSONAL_GAIN = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TIME_STEP = 2'd2;

  // operation codes
  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_MOVE = 1'b1;

  localparam logic [GAIN_W-1:0] GLOBAL_GAIN_RST = 16'd2048;
  localparam logic [GAIN_W-1:0] PERSONAL_GAIN_RST = 16'd2048;
  localparam logic [GAIN_W-1:0] TIME_STEP_RST = 16'd6554;

  localparam logic signed [FIT_W-1:0] FIT_MIN = 18'sh20000;
  localparam logic signed [POS_W-1:0] WIN_HI = 24'sd411775;
  localparam logic signed [POS_W-1:0] WIN_LO = -24'sd411775;

  // angle constants in Q.30
  localparam logic [37:0] Q30_TWO_PI = 38'd6746518852;
  localparam logic [37:0] Q30_PI = 38'd3373259426;
  localparam logic [37:0] Q30_HALF_PI = 38'd1686629713;
  localparam logic [32:0] Q30_ONE = 33'd1073741824;
  localparam logic [47:0] DEN_BIAS = 48'h6_0000_0000;

  localparam int HORNER_STEPS = 6;

  typedef struct packed {
    logic signed [POS_W-1:0] pos_x;
    logic signed [POS_W-1:0] pos_y;
    logic signed [POS_W-1:0] vel_x;
    logic signed [POS_W-1:0] vel_y;
    logic signed [FIT_W-1:0] cur_fit;
    logic signed [POS_W-1:0] own_x;
    logic signed [POS_W-1:0] own_y;
    logic signed [FIT_W-1:0] own_fit;
  } row_t;

  function automatic logic signed [POS_W-1:0] sat24(input logic signed [63:0] v);
    if (v > 64'sd8388607) begin
      return 24'sh7fffff;
    end else if (v < -64'sd8388608) begin
      return 24'sh800000;
    end
    return v[POS_W-1:0];
  endfunction

  // divisors of the cosine series, highest order first
  function automatic logic [7:0] horner_div(input logic [2:0] k);
    case (k)
      3'd0: return 8'd132;
      3'd1: return 8'd90;
      3'd2: return 8'd56;
      3'd3: return 8'd30;
      3'd4: return 8'd12;
      default: return 8'd2;
    endcase
  endfunction

  // floor(2^32 / divisor)
  function automatic logic [31:0] horner_recip(input logic [2:0] k);
    case (k)
      3'd0: return 32'd32537631;
      3'd1: return 32'd47721858;
      3'd2: return 32'd76695844;
      3'd3: return 32'd143165576;
      3'd4: return 32'd357913941;
      default: return 32'd2147483648;
    endcase
  endfunction

endpackage

`default_nettype wire

>>> design/pso_particle_update.sv
// Particle swarm step over a stored swarm: load or move one particle and score it.
// One item is taken at a time. A load always scores the loaded position. A move
// scores the new position when it lies inside the scoring window of +-2pi and
// skips the scoring when it lies outside. Either kind of move goes through the
// OFFER state only when the personal best is replaced. The block is ready again
// in the same cycle as the result is presented, and later if an earlier result
// still fills the output register. All products go through one shared 33x33
// multiplier in turn; scoring adds a bit-serial square root (24 steps), a 5-step
// angle reduction, a cosine series of six Horner steps (states H1 to H5 each) and
// a bit-serial divide (18 steps). Particle state sits in one memory row per
// particle; a move of a particle never loaded returns undefined values. Items
// whose index is not below PARTICLES are taken and dropped without a result. The
// next item is taken while the previous result still waits at the output register.
`timescale 1ns / 1ps
`default_nettype none

module pso_particle_update
  import pso_pkg::*;
#(
  parameter int PARTICLES = 32
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  // item in
  input  wire logic                  s_axis_tvalid,
  output logic                       s_axis_tready,
  // particle_index, load_pos_x, load_pos_y, load_vel_x, load_vel_y,
  // rand_global_x, rand_personal_x, rand_global_y, rand_personal_y
  input  wire logic [IN_DATA_W-1:0]  s_axis_tdata,
  // operation
  input  wire logic                  s_axis_tuser,
  // item out
  output logic                       m_axis_tvalid,
  input  wire logic                  m_axis_tready,
  // out_index, out_pos_x, out_pos_y, out_fitness, improved, best_fitness,
  // best_x, best_y
  output logic [OUT_DATA_W-1:0]      m_axis_tdata,
  // configuration
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [GAIN_W-1:0]     cfg_data
);

  localparam int AW = (PARTICLES > 1) ? $clog2(PARTICLES) : 1;

  typedef enum logic [5:0] {
    IDLE, RD, MV_X, MV_Y, MV_W, WIN,
    SQ_X, SQ_Y, SQ_S, ISQ, TSET, MODR, FOLD1, FOLD2, USQ, USET,
    H1, H2, H3, H4, H5, FIN, DIV, FIT,
    V1, V2, V3, V4, V5, DECIDE, OFFER, WR, DONE
  } state_t;

  state_t state;

  logic [GAIN_W-1:0] global_gain, personal_gain, time_step;

  logic [IDX_W-1:0] idx;
  logic [AW-1:0] addr;
  logic op_move;
  logic signed [POS_W-1:0] px, py, vx, vy, ox, oy;
  logic signed [FIT_W-1:0] cf, of;
  logic signed [POS_W-1:0] sbx, sby;
  logic signed [FIT_W-1:0] sbf;
  logic signed [RAND_W-1:0] rgx, rpx, rgy, rpy;
  logic improved;

  logic signed [32:0] ma, mb;
  logic signed [65:0] prod;

  logic [47:0] s, sq_rem, sq_res, sq_bit;
  logic [4:0] cnt;
  logic [37:0] t;
  logic neg;
  logic [31:0] u;
  logic signed [32:0] acc;
  logic [2:0] kk;
  logic pneg;
  logic [31:0] v, q0;
  logic cneg;
  logic [64:0] rem, dsh;
  logic [FIT_W-1:0] quo;
  logic signed [59:0] vsum;
  logic axis;

  row_t mem [PARTICLES];
  row_t mem_q;
  row_t row_w;

  // input unpacking
  logic [IDX_W-1:0] in_idx;
  logic in_range, accept, rd_en;
  assign in_idx = s_axis_tdata[4:0];
  assign in_range = (32'(in_idx) < PARTICLES);
  assign s_axis_tready = (state == IDLE);
  assign accept = s_axis_tvalid && s_axis_tready;
  assign rd_en = accept && in_range && (s_axis_tuser == OP_MOVE);

  always_ff @(posedge clk) begin
    if (rd_en) begin
      mem_q <= mem[AW'(in_idx)];
    end
    if (state == WR) begin
      mem[addr] <= row_w;
    end
  end

  assign row_w = '{pos_x: px, pos_y: py, vel_x: vx, vel_y: vy, cur_fit: cf,
                   own_x: ox, own_y: oy, own_fit: of};

  // shared multiplier operand select
  logic signed [POS_W:0] diff_g, diff_p;
  assign diff_g = axis ? (25'(sby) - 25'(py)) : (25'(sbx) - 25'(px));
  assign diff_p = axis ? (25'(oy) - 25'(py)) : (25'(ox) - 25'(px));

  always_comb begin
    ma = '0;
    mb = '0;
    case (state)
      MV_X: begin
        ma = 33'(vx);
        mb = $signed(33'(time_step));
      end
      MV_Y: begin
        ma = 33'(vy);
        mb = $signed(33'(time_step));
      end
      SQ_X: begin
        ma = 33'(px);
        mb = 33'(px);
      end
      SQ_Y: begin
        ma = 33'(py);
        mb = 33'(py);
      end
      USQ: begin
        ma = $signed(33'(t[30:0]));
        mb = $signed(33'(t[30:0]));
      end
      H1: begin
        ma = $signed(33'(u));
        mb = acc;
      end
      H3: begin
        ma = $signed(33'(v));
        mb = $signed(33'(horner_recip(kk)));
      end
      H4: begin
        ma = $signed(33'(prod[63:32]));
        mb = $signed(33'(horner_div(kk)));
      end
      V1: begin
        ma = $signed(33'(global_gain));
        mb = 33'(axis ? rgy : rgx);
      end
      V2: begin
        ma = $signed(prod[32:0]);
        mb = 33'(diff_g);
      end
      V3: begin
        ma = $signed(33'(personal_gain));
        mb = 33'(axis ? rpy : rpx);
      end
      V4: begin
        ma = $signed(prod[32:0]);
        mb = 33'(diff_p);
      end
      default: begin
        ma = '0;
        mb = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    prod <= ma * mb;
  end

  // datapath helpers
  logic [48:0] sq_try;
  logic [37:0] mod_lim;
  logic signed [65:0] pabs;
  logic [32:0] h_rem, h_q;
  logic [32:0] aabs;
  logic [47:0] den;
  logic dv_ge;
  logic signed [40:0] step_adj;
  logic signed [59:0] vtot, vadj;
  logic signed [POS_W-1:0] cur_vel, new_vel;

  assign sq_try = {1'b0, sq_res} + {1'b0, sq_bit};
  assign mod_lim = Q30_TWO_PI << cnt[2:0];
  assign pabs = prod[65] ? -prod : prod;
  assign h_rem = {1'b0, v} - prod[32:0];
  assign h_q = {1'b0, q0} + ((h_rem >= 33'(horner_div(kk))) ? 33'd1 : 33'd0);
  assign aabs = acc[32] ? 33'(-acc) : 33'(acc);
  assign den = s + DEN_BIAS;
  assign dv_ge = (rem >= dsh);
  assign step_adj = prod[40:0] + (prod[40] ? 41'sd65535 : 41'sd0);
  assign vtot = vsum + 60'(prod);
  assign vadj = vtot + (vtot[59] ? 60'sd134217727 : 60'sd0);
  assign cur_vel = axis ? vy : vx;
  assign new_vel = sat24(64'(cur_vel) + 64'(vadj >>> 27));

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= IDLE;
      m_axis_tvalid <= 1'b0;
      global_gain <= GLOBAL_GAIN_RST;
      personal_gain <= PERSONAL_GAIN_RST;
      time_step <= TIME_STEP_RST;
      sbx <= '0;
      sby <= '0;
      sbf <= FIT_MIN;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_GLOBAL_GAIN: global_gain <= cfg_data;
          CFG_PERSONAL_GAIN: personal_gain <= cfg_data;
          CFG_TIME_STEP: time_step <= cfg_data;
          default: ;
        endcase
      end
      if (m_axis_tready && state != DONE) begin
        m_axis_tvalid <= 1'b0;
      end
      case (state)
        IDLE: begin
          if (accept && in_range) begin
            idx <= in_idx;
            addr <= AW'(in_idx);
            op_move <= s_axis_tuser;
            rgx <= s_axis_tdata[116:101];
            rpx <= s_axis_tdata[132:117];
            rgy <= s_axis_tdata[148:133];
            rpy <= s_axis_tdata[164:149];
            if (s_axis_tuser == OP_MOVE) begin
              state <= RD;
            end else begin
              px <= s_axis_tdata[28:5];
              py <= s_axis_tdata[52:29];
              vx <= s_axis_tdata[76:53];
              vy <= s_axis_tdata[100:77];
              improved <= 1'b1;
              if (in_idx == '0) begin
                sbf <= FIT_MIN;
              end
              state <= SQ_X;
            end
          end
        end
        RD: begin
          px <= mem_q.pos_x;
          py <= mem_q.pos_y;
          vx <= mem_q.vel_x;
          vy <= mem_q.vel_y;
          cf <= mem_q.cur_fit;
          ox <= mem_q.own_x;
          oy <= mem_q.own_y;
          of <= mem_q.own_fit;
          state <= MV_X;
        end
        MV_X: state <= MV_Y;
        MV_Y: begin
          px <= sat24(64'(px) + 64'(step_adj >>> 16));
          state <= MV_W;
        end
        MV_W: begin
          py <= sat24(64'(py) + 64'(step_adj >>> 16));
          state <= WIN;
        end
        WIN: begin
          axis <= 1'b0;
          if (px > WIN_LO && px < WIN_HI && py > WIN_LO && py < WIN_HI) begin
            state <= SQ_X;
          end else begin
            state <= V1;
          end
        end
        SQ_X: state <= SQ_Y;
        SQ_Y: begin
          s <= prod[47:0];
          state <= SQ_S;
        end
        SQ_S: begin
          s <= s + prod[47:0];
          sq_rem <= s + prod[47:0];
          sq_res <= '0;
          sq_bit <= 48'h4000_0000_0000;
          cnt <= 5'd23;
          state <= ISQ;
        end
        ISQ: begin
          // one result bit per cycle
          if ({1'b0, sq_rem} >= sq_try) begin
            sq_rem <= sq_rem - sq_try[47:0];
            sq_res <= (sq_res >> 1) + sq_bit;
          end else begin
            sq_res <= sq_res >> 1;
          end
          sq_bit <= sq_bit >> 2;
          if (cnt == '0) begin
            state <= TSET;
          end else begin
            cnt <= cnt - 5'd1;
          end
        end
        TSET: begin
          t <= {sq_res[23:0], 14'b0};
          cnt <= 5'd4;
          state <= MODR;
        end
        MODR: begin
          // reduce modulo 2pi, one power-of-two multiple of 2pi (16 down to 1) per cycle
          if (t >= mod_lim) begin
            t <= t - mod_lim;
          end
          if (cnt == '0) begin
            state <= FOLD1;
          end else begin
            cnt <= cnt - 5'd1;
          end
        end
        FOLD1: begin
          if (t > Q30_PI) begin
            t <= Q30_TWO_PI - t;
          end
          state <= FOLD2;
        end
        FOLD2: begin
          if (t > Q30_HALF_PI) begin
            t <= Q30_PI - t;
            neg <= 1'b1;
          end else begin
            neg <= 1'b0;
          end
          state <= USQ;
        end
        USQ: state <= USET;
        USET: begin
          u <= prod[61:30];
          acc <= $signed(Q30_ONE);
          kk <= '0;
          state <= H1;
        end
        H1: state <= H2;
        H2: begin
          pneg <= prod[65];
          v <= pabs[61:30];
          state <= H3;
        end
        H3: state <= H4;
        H4: begin
          q0 <= prod[63:32];
          state <= H5;
        end
        H5: begin
          // estimate from the reciprocal is low by at most one
          acc <= pneg ? $signed(Q30_ONE + h_q) : $signed(Q30_ONE - h_q);
          if (kk == 3'(HORNER_STEPS - 1)) begin
            state <= FIN;
          end else begin
            kk <= kk + 3'd1;
            state <= H1;
          end
        end
        FIN: begin
          cneg <= neg ^ acc[32];
          rem <= (65'(aabs) << 20) + (65'(aabs) << 19);
          dsh <= {den, 17'b0};
          quo <= '0;
          cnt <= 5'd17;
          state <= DIV;
        end
        DIV: begin
          if (dv_ge) begin
            rem <= rem - dsh;
          end
          quo <= {quo[FIT_W-2:0], dv_ge};
          dsh <= dsh >> 1;
          if (cnt == '0) begin
            state <= FIT;
          end else begin
            cnt <= cnt - 5'd1;
          end
        end
        FIT: begin
          cf <= cneg ? $signed(-quo) : $signed(quo);
          axis <= 1'b0;
          state <= op_move ? V1 : OFFER;
        end
        V1: state <= V2;
        V2: state <= V3;
        V3: begin
          vsum <= 60'(prod);
          state <= V4;
        end
        V4: state <= V5;
        V5: begin
          if (axis) begin
            vy <= new_vel;
            state <= DECIDE;
          end else begin
            vx <= new_vel;
            axis <= 1'b1;
            state <= V1;
          end
        end
        DECIDE: begin
          improved <= (cf > of);
          state <= (cf > of) ? OFFER : WR;
        end
        OFFER: begin
          ox <= px;
          oy <= py;
          of <= cf;
          if (cf > sbf) begin
            sbx <= px;
            sby <= py;
            sbf <= cf;
          end
          state <= WR;
        end
        WR: state <= DONE;
        DONE: begin
          if (!m_axis_tvalid || m_axis_tready) begin
            m_axis_tvalid <= 1'b1;
            m_axis_tdata <= {6'b0, sby, sbx, sbf, improved, cf, py, px, idx};
            state <= IDLE;
          end
        end
        default: state <= IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire
